// ===== rtl/core/ktr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ktr_pkg;

    localparam int HELD_DEPTH  = 4;
    localparam int MAX_RESULTS = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CODE_GEM  = 8'd35;
    localparam logic [7:0] CODE_LONG = 8'd85;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_MISPLACED = 2'd2;

    // no letter in this table slot
    localparam logic [7:0] NO = 8'h00;

    typedef enum logic [2:0] {
        KIND_N,
        KIND_S,
        KIND_Y,
        KIND_W,
        KIND_G,
        KIND_L,
        KIND_X
    } kind_t;

    typedef struct packed {
        logic [6:0] c1;
        logic [6:0] c2;
        logic [6:0] v;
        kind_t      kind;
    } entry_t;

    typedef struct packed {
        logic [7:0] kana_code;
        logic       word_end;
    } in_t;

    typedef struct packed {
        logic [6:0] letter;
        logic [1:0] status;
        logic       last_of_word;
    } out_t;

    // letters of one item; status and last flag belong to the final entry
    typedef struct packed {
        logic [MAX_RESULTS-1:0][6:0]     letters;
        logic [$clog2(MAX_RESULTS+1)-1:0] n;
        logic [1:0]                       status;
        logic                             mark_last;
    } bundle_t;

    function automatic entry_t ent(logic [7:0] c1, logic [7:0] c2, logic [7:0] v, kind_t k);
        entry_t r;
        r.c1   = c1[6:0];
        r.c2   = c2[6:0];
        r.v    = v[6:0];
        r.kind = k;
        return r;
    endfunction

    function automatic entry_t kana_entry(logic [7:0] code);
        entry_t e;
        case (code)
            8'd1:  e = ent(NO, NO, "a", KIND_S);
            8'd2:  e = ent(NO, NO, "a", KIND_N);
            8'd3:  e = ent(NO, NO, "i", KIND_S);
            8'd4:  e = ent(NO, NO, "i", KIND_N);
            8'd5:  e = ent(NO, NO, "u", KIND_S);
            8'd6:  e = ent(NO, NO, "u", KIND_N);
            8'd7:  e = ent(NO, NO, "e", KIND_S);
            8'd8:  e = ent(NO, NO, "e", KIND_N);
            8'd9:  e = ent(NO, NO, "o", KIND_S);
            8'd10: e = ent(NO, NO, "o", KIND_N);
            8'd11: e = ent("k", NO, "a", KIND_N);
            8'd12: e = ent("g", NO, "a", KIND_N);
            8'd13: e = ent("k", NO, "i", KIND_N);
            8'd14: e = ent("g", NO, "i", KIND_N);
            8'd15: e = ent("k", NO, "u", KIND_N);
            8'd16: e = ent("g", NO, "u", KIND_N);
            8'd17: e = ent("k", NO, "e", KIND_N);
            8'd18: e = ent("g", NO, "e", KIND_N);
            8'd19: e = ent("k", NO, "o", KIND_N);
            8'd20: e = ent("g", NO, "o", KIND_N);
            8'd21: e = ent("s", NO, "a", KIND_N);
            8'd22: e = ent("z", NO, "a", KIND_N);
            8'd23: e = ent("s", "h", "i", KIND_N);
            8'd24: e = ent("j", NO, "i", KIND_N);
            8'd25: e = ent("s", NO, "u", KIND_N);
            8'd26: e = ent("z", NO, "u", KIND_N);
            8'd27: e = ent("s", NO, "e", KIND_N);
            8'd28: e = ent("z", NO, "e", KIND_N);
            8'd29: e = ent("s", NO, "o", KIND_N);
            8'd30: e = ent("z", NO, "o", KIND_N);
            8'd31: e = ent("t", NO, "a", KIND_N);
            8'd32: e = ent("d", NO, "a", KIND_N);
            8'd33: e = ent("c", "h", "i", KIND_N);
            8'd34: e = ent("j", NO, "i", KIND_N);
            CODE_GEM: e = ent(NO, NO, NO, KIND_G);
            8'd36: e = ent("t", "s", "u", KIND_N);
            8'd37: e = ent("z", NO, "u", KIND_N);
            8'd38: e = ent("t", NO, "e", KIND_N);
            8'd39: e = ent("d", NO, "e", KIND_N);
            8'd40: e = ent("t", NO, "o", KIND_N);
            8'd41: e = ent("d", NO, "o", KIND_N);
            8'd42: e = ent("n", NO, "a", KIND_N);
            8'd43: e = ent("n", NO, "i", KIND_N);
            8'd44: e = ent("n", NO, "u", KIND_N);
            8'd45: e = ent("n", NO, "e", KIND_N);
            8'd46: e = ent("n", NO, "o", KIND_N);
            8'd47: e = ent("h", NO, "a", KIND_N);
            8'd48: e = ent("b", NO, "a", KIND_N);
            8'd49: e = ent("p", NO, "a", KIND_N);
            8'd50: e = ent("h", NO, "i", KIND_N);
            8'd51: e = ent("b", NO, "i", KIND_N);
            8'd52: e = ent("p", NO, "i", KIND_N);
            8'd53: e = ent("f", NO, "u", KIND_N);
            8'd54: e = ent("b", NO, "u", KIND_N);
            8'd55: e = ent("p", NO, "u", KIND_N);
            8'd56: e = ent("h", NO, "e", KIND_N);
            8'd57: e = ent("b", NO, "e", KIND_N);
            8'd58: e = ent("p", NO, "e", KIND_N);
            8'd59: e = ent("h", NO, "o", KIND_N);
            8'd60: e = ent("b", NO, "o", KIND_N);
            8'd61: e = ent("p", NO, "o", KIND_N);
            8'd62: e = ent("m", NO, "a", KIND_N);
            8'd63: e = ent("m", NO, "i", KIND_N);
            8'd64: e = ent("m", NO, "u", KIND_N);
            8'd65: e = ent("m", NO, "e", KIND_N);
            8'd66: e = ent("m", NO, "o", KIND_N);
            8'd67: e = ent(NO, NO, "a", KIND_Y);
            8'd68: e = ent("y", NO, "a", KIND_N);
            8'd69: e = ent(NO, NO, "u", KIND_Y);
            8'd70: e = ent("y", NO, "u", KIND_N);
            8'd71: e = ent(NO, NO, "o", KIND_Y);
            8'd72: e = ent("y", NO, "o", KIND_N);
            8'd73: e = ent("r", NO, "a", KIND_N);
            8'd74: e = ent("r", NO, "i", KIND_N);
            8'd75: e = ent("r", NO, "u", KIND_N);
            8'd76: e = ent("r", NO, "e", KIND_N);
            8'd77: e = ent("r", NO, "o", KIND_N);
            8'd78: e = ent(NO, NO, "a", KIND_W);
            8'd79: e = ent("w", NO, "a", KIND_N);
            8'd80: e = ent("w", NO, "i", KIND_N);
            8'd81: e = ent("w", NO, "e", KIND_N);
            8'd82: e = ent("w", NO, "o", KIND_N);
            8'd83: e = ent("n", NO, NO, KIND_N);
            8'd84: e = ent("v", NO, "u", KIND_N);
            CODE_LONG: e = ent(NO, NO, NO, KIND_L);
            default: e = ent(NO, NO, NO, KIND_X);
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ktr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ktr_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ktr_pkg::bundle_t  wdata,
    output logic                   full,
    input  wire logic              pop,
    output ktr_pkg::bundle_t       rdata,
    output logic                   empty
);

    localparam int PW = (ktr_pkg::QUEUE_DEPTH > 1) ? $clog2(ktr_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(ktr_pkg::QUEUE_DEPTH + 1);

    ktr_pkg::bundle_t entries_reg [ktr_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(ktr_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entries_reg[rptr_reg];

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(ktr_pkg::QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        wptr_next  = do_push ? ptr_inc(wptr_reg) : wptr_reg;
        rptr_next  = do_pop ? ptr_inc(rptr_reg) : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ktr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ktr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire ktr_pkg::in_t  item,
    output logic               q_push,
    output ktr_pkg::bundle_t   q_data
);

    localparam logic [6:0] LTR_C = 7'h63;
    localparam logic [6:0] LTR_H = 7'h68;
    localparam logic [6:0] LTR_I = 7'h69;
    localparam logic [6:0] LTR_J = 7'h6a;
    localparam logic [6:0] LTR_S = 7'h73;
    localparam logic [6:0] LTR_T = 7'h74;
    localparam logic [6:0] LTR_Y = 7'h79;

    typedef struct packed {
        logic [ktr_pkg::HELD_DEPTH-1:0][6:0] letters;
        logic [2:0]                          cnt;
        logic [6:0]                          prev;
    } hold_t;

    logic [ktr_pkg::HELD_DEPTH-1:0][6:0] letters_reg;
    logic [2:0] cnt_reg;
    logic [6:0] prev_reg;
    logic       gem_reg, start_reg, skip_reg;

    hold_t            h;
    logic             gem_next, start_next, skip_next;
    ktr_pkg::bundle_t b;

    function automatic hold_t hold_push(hold_t s, logic [6:0] c);
        hold_t r;
        r = s;
        if (s.cnt < 3'(ktr_pkg::HELD_DEPTH))
        begin
            r.letters[s.cnt[1:0]] = c;
            r.cnt  = s.cnt + 3'd1;
            r.prev = c;
        end
        return r;
    endfunction

    function automatic ktr_pkg::bundle_t emit_push(ktr_pkg::bundle_t s, logic [6:0] c);
        ktr_pkg::bundle_t r;
        r = s;
        if (s.n < 4'(ktr_pkg::MAX_RESULTS))
        begin
            r.letters[s.n[2:0]] = c;
            r.n = s.n + 4'd1;
        end
        return r;
    endfunction

    // append the held syllable to the transaction list
    function automatic ktr_pkg::bundle_t emit_held(ktr_pkg::bundle_t s, hold_t hs);
        ktr_pkg::bundle_t r;
        r = s;
        for (int i = 0; i < ktr_pkg::HELD_DEPTH; i++)
        begin
            if (3'(i) < hs.cnt)
            begin
                r = emit_push(r, hs.letters[i]);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        ktr_pkg::entry_t e;
        logic            err;
        logic [6:0]      p;
        logic [6:0]      removed;
        logic [6:0]      last;
        logic [6:0]      before_last;
        logic            no_y;

        e           = ktr_pkg::kana_entry(item.kana_code);
        h.letters   = letters_reg;
        h.cnt       = cnt_reg;
        h.prev      = prev_reg;
        gem_next    = gem_reg;
        start_next  = start_reg;
        skip_next   = skip_reg;
        b           = '0;
        p           = prev_reg;
        removed     = '0;
        last        = '0;
        before_last = '0;
        no_y        = 1'b0;
        err = (e.kind == ktr_pkg::KIND_X) || (start_reg && e.kind != ktr_pkg::KIND_N);

        if (skip_reg)
        begin
            if (item.word_end)
            begin
                skip_next = 1'b0;
            end
        end
        else if (err)
        begin
            b = emit_held(b, h);
            b = emit_push(b, 7'd0);
            b.status    = (e.kind == ktr_pkg::KIND_X) ? ktr_pkg::ST_INVALID
                                                       : ktr_pkg::ST_MISPLACED;
            b.mark_last = 1'b1;
            h.cnt       = '0;
            h.prev      = '0;
            gem_next    = 1'b0;
            start_next  = 1'b1;
            skip_next   = !item.word_end;
        end
        else
        begin
            case (e.kind)
                ktr_pkg::KIND_L:
                begin
                    b     = emit_held(b, h);
                    h.cnt = '0;
                    if (p != 7'd0)
                    begin
                        h = hold_push(h, p);
                    end
                end
                ktr_pkg::KIND_G:
                begin
                    b        = emit_held(b, h);
                    h.cnt    = '0;
                    gem_next = 1'b1;
                end
                ktr_pkg::KIND_S, ktr_pkg::KIND_Y:
                begin
                    gem_next = 1'b0;
                    if (h.cnt != 3'd0)
                    begin
                        removed = h.letters[2'(h.cnt - 3'd1)];
                        h.cnt   = h.cnt - 3'd1;
                        if (e.kind == ktr_pkg::KIND_Y && removed == LTR_I && h.cnt != 3'd0)
                        begin
                            last        = h.letters[2'(h.cnt - 3'd1)];
                            before_last = h.letters[2'(h.cnt - 3'd2)];
                            // sh, ch and j already carry the y sound
                            no_y = (last == LTR_J) ||
                                   (h.cnt >= 3'd2 && last == LTR_H &&
                                    (before_last == LTR_S || before_last == LTR_C));
                            if (!no_y)
                            begin
                                h = hold_push(h, LTR_Y);
                            end
                        end
                    end
                    h = hold_push(h, e.v);
                end
                default:
                begin
                    b     = emit_held(b, h);
                    h.cnt = '0;
                    if (gem_reg && e.c1 != 7'd0)
                    begin
                        h = hold_push(h, (e.c1 == LTR_C) ? LTR_T : e.c1);
                    end
                    gem_next = 1'b0;
                    if (e.c1 != 7'd0)
                    begin
                        h = hold_push(h, e.c1);
                    end
                    if (e.c2 != 7'd0)
                    begin
                        h = hold_push(h, e.c2);
                    end
                    if (e.v != 7'd0)
                    begin
                        h = hold_push(h, e.v);
                    end
                end
            endcase
            start_next = 1'b0;

            if (item.word_end)
            begin
                if (h.cnt != 3'd0)
                begin
                    b = emit_held(b, h);
                end
                else if (b.n == 4'd0)
                begin
                    b = emit_push(b, 7'd0);
                end
                b.mark_last = 1'b1;
                h.cnt       = '0;
                h.prev      = '0;
                gem_next    = 1'b0;
                start_next  = 1'b1;
            end
        end
    end

    assign q_push = accept && (b.n != 4'd0);
    assign q_data = b;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            letters_reg <= h.letters;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            prev_reg  <= '0;
            gem_reg   <= 1'b0;
            start_reg <= 1'b1;
            skip_reg  <= 1'b0;
        end
        else if (accept)
        begin
            cnt_reg   <= h.cnt;
            prev_reg  <= h.prev;
            gem_reg   <= gem_next;
            start_reg <= start_next;
            skip_reg  <= skip_next;
        end
    end

    // a dropped word always restarts at a word boundary
    assert property (@(posedge clk) disable iff (!rst_n) skip_reg |-> start_reg)
        else $error("skipping a word while not at word start");

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(ktr_pkg::HELD_DEPTH))
        else $error("held syllable overflow");

endmodule

`default_nettype wire

// ===== rtl/core/ktr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ktr_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire ktr_pkg::bundle_t  q_data,
    output logic                   q_pop,
    output ktr_pkg::out_t          result,
    output logic                   empty,
    input  wire logic              pop
);

    ktr_pkg::bundle_t cur_reg;
    logic             valid_reg, valid_next;
    logic [2:0]       idx_reg, idx_next;
    logic             at_last, load;

    assign at_last = (({1'b0, idx_reg} + 4'd1) == cur_reg.n);
    assign load    = !valid_reg || (pop && at_last);
    assign q_pop   = load && !q_empty;
    assign empty   = !valid_reg;

    always_comb
    begin
        result.letter       = cur_reg.letters[idx_reg];
        result.status       = at_last ? cur_reg.status : ktr_pkg::ST_OK;
        result.last_of_word = at_last && cur_reg.mark_last;
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = !q_empty;
            idx_next   = '0;
        end
        else if (pop)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cur_reg.n != 4'd0 && cur_reg.n <= 4'(ktr_pkg::MAX_RESULTS)))
        else $error("empty or oversized transaction list in output stage");

    // an error status only appears on the closing result of a word
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != ktr_pkg::ST_OK) |-> result.last_of_word)
        else $error("error status on a result that does not end the word");

endmodule

`default_nettype wire

// ===== rtl/core/katakana_to_romaji_top.sv =====
// the first result of an item is registered in the two-entry queue and then in the output stage
// one result per cycle while pop is asserted; an item occupies the output until all of its results
// (1 to 8) are popped, and an item with no result puts nothing in the queue
// input is taken every cycle while the two-entry queue between front and back has room
// reset clears word state, queue and output stage; the held-letter store is not cleared
`timescale 1ns / 1ps
`default_nettype none

module katakana_to_romaji_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire ktr_pkg::in_t  item,
    output logic               empty,
    input  wire logic          pop,
    output ktr_pkg::out_t      result
);

    ktr_pkg::bundle_t fq_data;
    ktr_pkg::bundle_t qb_data;
    logic             fq_push;
    logic             qb_pop;
    logic             qb_empty;
    logic             accept;

    assign accept = push && !full;

    ktr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .q_push (fq_push),
        .q_data (fq_data)
    );

    ktr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata (fq_data),
        .full  (full),
        .pop   (qb_pop),
        .rdata (qb_data),
        .empty (qb_empty)
    );

    ktr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (qb_empty),
        .q_data  (qb_data),
        .q_pop   (qb_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

`default_nettype wire
